>>> rtl/gau_pkg.sv
package gau_pkg;

    // Operand and result width of every datapath word.
    localparam int DATA_W = 64;

    // Configuration port geometry: three 64-bit registers at 8-byte spacing.
    localparam int APB_AW = 5;
    localparam int APB_DW = 64;

    // Register indexes, taken from paddr[4:3].
    localparam logic [1:0] REG_MODE    = 2'd0;
    localparam logic [1:0] REG_WIDE    = 2'd1;
    localparam logic [1:0] REG_DEFAULT = 2'd2;

    // Aggregate mode codes. Codes five to seven behave as count.
    localparam logic [2:0] MODE_COUNT = 3'd0;
    localparam logic [2:0] MODE_MIN   = 3'd1;
    localparam logic [2:0] MODE_MAX   = 3'd2;
    localparam logic [2:0] MODE_SUM   = 3'd3;
    localparam logic [2:0] MODE_AVG   = 3'd4;

    // Input item function codes.
    localparam logic FUNC_GROUP = 1'b0;
    localparam logic FUNC_FOLD  = 1'b1;

    // Saturation limits of the signed average.
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    typedef struct packed {
        logic                     func;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] result;
        logic                     is_empty;
    } t_out_item;

    // Result of one serial fold pass.
    typedef struct packed {
        logic [DATA_W-1:0] sum;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] extreme;
        logic              v_lt_x;
        logic              x_lt_v;
    } t_fold_result;

    // Sign extend the low 32 bits in narrow mode, pass through in wide mode.
    function automatic logic [DATA_W-1:0] fit(input logic [DATA_W-1:0] u,
                                              input logic wide);
        logic [DATA_W-1:0] r;
        r = wide ? u : {{(DATA_W-32){u[31]}}, u[31:0]};
        return r;
    endfunction

endpackage

>>> rtl/gau_fold.sv
module gau_fold
    import gau_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_value,
    input  logic [DATA_W-1:0] i_extreme,
    input  logic [DATA_W-1:0] i_total,
    output logic              o_done,
    output t_fold_result      o_res
);

    localparam int CW = $clog2(DATA_W);
    localparam logic [CW-1:0] LAST = CW'(DATA_W - 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [DATA_W-1:0] r_v, n_v;
    logic [DATA_W-1:0] r_x, n_x;
    logic [DATA_W-1:0] r_t, n_t;
    logic              r_c, n_c;
    logic              r_lt, n_lt;
    logic              r_gt, n_gt;

    logic w_vb, w_xb, w_tb, w_sign;

    assign w_vb   = r_v[0];
    assign w_xb   = r_x[0];
    assign w_tb   = r_t[0];
    assign w_sign = (r_cnt == LAST);

    // One bit per cycle, LSB first: serial adder for the total and a
    // running signed compare; value and extreme rotate back into place.
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_v    = r_v;
        n_x    = r_x;
        n_t    = r_t;
        n_c    = r_c;
        n_lt   = r_lt;
        n_gt   = r_gt;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_v    = i_value;
            n_x    = i_extreme;
            n_t    = i_total;
            n_c    = 1'b0;
            n_lt   = 1'b0;
            n_gt   = 1'b0;
        end else if (r_busy) begin
            n_v = {w_vb, r_v[DATA_W-1:1]};
            n_x = {w_xb, r_x[DATA_W-1:1]};
            n_t = {w_tb ^ w_vb ^ r_c, r_t[DATA_W-1:1]};
            n_c = (w_tb & w_vb) | (w_tb & r_c) | (w_vb & r_c);
            // A higher differing bit overrides the verdict so far; the sign
            // bit ranks the other way round.
            if (w_vb != w_xb) begin
                n_lt = w_sign ? w_vb : w_xb;
                n_gt = w_sign ? w_xb : w_vb;
            end
            n_cnt = r_cnt + 1'b1;
            if (w_sign) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_v   <= n_v;
        r_x   <= n_x;
        r_t   <= n_t;
        r_c   <= n_c;
        r_lt  <= n_lt;
        r_gt  <= n_gt;
    end

    assign o_done         = r_done;
    assign o_res.sum      = r_t;
    assign o_res.value    = r_v;
    assign o_res.extreme  = r_x;
    assign o_res.v_lt_x   = r_lt;
    assign o_res.x_lt_v   = r_gt;

endmodule

>>> rtl/gau_div.sv
module gau_div
    import gau_pkg::*;
#(
    parameter int COUNT_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DATA_W-1:0]     i_total,
    input  logic [COUNT_BITS-1:0] i_count,
    output logic                  o_done,
    output logic [DATA_W-1:0]     o_quot
);

    localparam int STEPS = DATA_W + FRAC_BITS;
    localparam int SW    = $clog2(STEPS + 1);
    localparam logic [SW-1:0] LAST = SW'(STEPS - 1);

    logic              r_busy, n_busy;
    logic              r_fin, n_fin;
    logic              r_done, n_done;
    logic [SW-1:0]     r_cnt, n_cnt;
    logic              r_neg, n_neg;
    logic              r_ovf, n_ovf;
    logic [DATA_W-1:0] r_dvd, n_dvd;
    logic [DATA_W-1:0] r_den, n_den;
    logic [DATA_W-1:0] r_rem, n_rem;
    logic [DATA_W-1:0] r_q, n_q;
    logic [DATA_W-1:0] r_quot, n_quot;

    logic [DATA_W-1:0] w_shift;
    logic              w_ge;

    // Partial remainder shifted by one dividend bit; zeros follow the
    // magnitude for the fraction bits.
    assign w_shift = {r_rem[DATA_W-2:0], r_dvd[DATA_W-1]};
    assign w_ge    = r_rem[DATA_W-1] || (w_shift >= r_den);

    // Restoring divider, one quotient bit per cycle, then a sign and
    // saturation step.
    always_comb begin
        n_busy = r_busy;
        n_fin  = 1'b0;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_neg  = r_neg;
        n_ovf  = r_ovf;
        n_dvd  = r_dvd;
        n_den  = r_den;
        n_rem  = r_rem;
        n_q    = r_q;
        n_quot = r_quot;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_neg  = i_total[DATA_W-1];
            n_ovf  = 1'b0;
            n_dvd  = i_total[DATA_W-1] ? (DATA_W'(0) - i_total) : i_total;
            n_den  = DATA_W'(i_count);
            n_rem  = '0;
            n_q    = '0;
        end else if (r_busy) begin
            n_dvd = {r_dvd[DATA_W-2:0], 1'b0};
            n_rem = w_ge ? (w_shift - r_den) : w_shift;
            n_ovf = r_ovf | r_q[DATA_W-1];
            n_q   = {r_q[DATA_W-2:0], w_ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LAST) begin
                n_busy = 1'b0;
                n_fin  = 1'b1;
            end
        end else if (r_fin) begin
            if (r_neg) begin
                n_quot = (r_ovf || (r_q[DATA_W-1] && (|r_q[DATA_W-2:0])))
                         ? SAT_MIN : (DATA_W'(0) - r_q);
            end else begin
                n_quot = (r_ovf || r_q[DATA_W-1]) ? SAT_MAX : r_q;
            end
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_fin  <= n_fin;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_neg  <= n_neg;
        r_ovf  <= n_ovf;
        r_dvd  <= n_dvd;
        r_den  <= n_den;
        r_rem  <= n_rem;
        r_q    <= n_q;
        r_quot <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

>>> rtl/group_aggregate_unit.sv
// Channel   Direction  Handshake                   Beat
// -------   ---------  --------------------------  ---------------------------
// in        input      i_in_valid / o_in_ready     t_in_item  (func, value)
// out       output     o_out_valid / i_out_ready   t_out_item (result, is_empty)
// config    input      APB psel/penable/pwrite     64-bit register, addr 8*i
//
// A group start goes from accept through S_RESULT and S_OUT to the output register.
// In a fold, the serial fold unit walks all 64 operand bits.
// In average mode with a non-empty group the restoring divider runs
// after S_RESULT, then a sign and saturation step.
// One beat is in work at a time; the output register holds a finished
// result while the next beat is accepted. Reset is synchronous, active low.
module group_aggregate_unit
    import gau_pkg::*;
#(
    parameter int COUNT_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FOLD   = 3'd1;
    localparam logic [2:0] S_RESULT = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    // Configuration registers.
    logic [2:0]        r_mode;
    logic              r_wide;
    logic [DATA_W-1:0] r_default;

    // Group state.
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [DATA_W-1:0]     r_extreme, n_extreme;
    logic [DATA_W-1:0]     r_total, n_total;

    // Control and result staging.
    logic [2:0]        r_state, n_state;
    logic [DATA_W-1:0] r_res, n_res;
    logic              r_res_empty, n_res_empty;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic         w_in_acc;
    logic         w_fold_start;
    logic         w_fold_done;
    t_fold_result w_fold;
    logic         w_div_start;
    logic         w_div_done;
    logic [DATA_W-1:0] w_quot;
    logic         w_wr;
    logic         w_take;

    assign w_in_acc     = i_in_valid && o_in_ready;
    assign w_fold_start = w_in_acc && (i_in_data.func == FUNC_FOLD);
    assign w_wr         = psel && penable && pwrite && pready;

    // Register file; the host must write it only while no beat is in work; the block does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_COUNT;
            r_wide    <= 1'b0;
            r_default <= '0;
        end else if (w_wr) begin
            case (paddr[4:3])
                REG_MODE:    r_mode    <= pwdata[2:0];
                REG_WIDE:    r_wide    <= pwdata[0];
                REG_DEFAULT: r_default <= pwdata;
                default:     ;
            endcase
        end
    end

    // Register readback.
    always_comb begin
        case (paddr[4:3])
            REG_MODE:    prdata = APB_DW'(r_mode);
            REG_WIDE:    prdata = APB_DW'(r_wide);
            REG_DEFAULT: prdata = r_default;
            default:     prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    gau_fold u_fold (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_fold_start),
        .i_value   (fit(i_in_data.value, r_wide)),
        .i_extreme (fit(r_extreme, r_wide)),
        .i_total   (fit(r_total, r_wide)),
        .o_done    (w_fold_done),
        .o_res     (w_fold)
    );

    gau_div #(
        .COUNT_BITS (COUNT_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_total (fit(r_total, r_wide)),
        .i_count (r_count),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_div_start = (r_state == S_RESULT) && (r_mode == MODE_AVG) && (r_count != '0);
    assign w_take      = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    // Sequencer: fold or clear the group, then pick the aggregate, divide for a
    // non-empty average, and hand the beat to the output register.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_extreme   = r_extreme;
        n_total     = r_total;
        n_res       = r_res;
        n_res_empty = r_res_empty;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_in_data.func == FUNC_FOLD) begin
                        n_state = S_FOLD;
                    end else begin
                        n_count   = '0;
                        n_extreme = '0;
                        n_total   = '0;
                        n_state   = S_RESULT;
                    end
                end
            end
            S_FOLD: begin
                if (w_fold_done) begin
                    if ((r_count == '0) ||
                        ((r_mode == MODE_MIN) && w_fold.v_lt_x) ||
                        ((r_mode == MODE_MAX) && w_fold.x_lt_v)) begin
                        n_extreme = w_fold.value;
                    end else begin
                        n_extreme = w_fold.extreme;
                    end
                    n_total = fit(w_fold.sum, r_wide);
                    if (r_count != '1) begin
                        n_count = r_count + 1'b1;
                    end
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                n_res_empty = (r_count == '0);
                n_state     = S_OUT;
                case (r_mode)
                    MODE_MIN, MODE_MAX: begin
                        n_res = (r_count != '0) ? fit(r_extreme, r_wide)
                                                : fit(r_default, r_wide);
                    end
                    MODE_SUM: begin
                        n_res = (r_count != '0) ? fit(r_total, r_wide)
                                                : fit(r_default, r_wide);
                    end
                    MODE_AVG: begin
                        if (r_count != '0) begin
                            n_state = S_DIV;
                        end else begin
                            n_res = r_default;
                        end
                    end
                    default: begin
                        n_res = DATA_W'(r_count);
                    end
                endcase
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_res   = w_quot;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register: loaded when free or being drained this cycle.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_take) begin
            n_out_valid     = 1'b1;
            n_out.result    = r_res;
            n_out.is_empty  = r_res_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_extreme   <= '0;
            r_total     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
            r_extreme   <= n_extreme;
            r_total     <= n_total;
        end
        r_res       <= n_res;
        r_res_empty <= n_res_empty;
        r_out       <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> bench/group_aggregate_unit_tb.sv
module group_aggregate_unit_tb;
    import gau_pkg::*;

    localparam int COUNT_BITS   = 32;
    localparam int FRAC_BITS    = 16;
    localparam int QUO_W        = DATA_W + FRAC_BITS;
    localparam int RANDOM_BEATS = 550;
    localparam int RUN_LIMIT    = 4_000_000;
    localparam int TAIL_CYCLES  = 160;

    // Highest unused mode code; codes above average behave as count.
    localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    t_in_item          i_in_data   = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_out_item         o_out_data;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [APB_AW-1:0] paddr       = '0;
    logic [APB_DW-1:0] pwdata      = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    group_aggregate_unit #(
        .COUNT_BITS(COUNT_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Shadow copy of the configuration registers.
    logic [2:0]        mode_cfg    = MODE_COUNT;
    logic              wide_cfg    = 1'b0;
    logic [DATA_W-1:0] default_cfg = '0;

    // Shadow copy of the group state.
    logic [COUNT_BITS-1:0] grp_count   = '0;
    logic [DATA_W-1:0]     grp_extreme = '0;
    logic [DATA_W-1:0]     grp_total   = '0;

    t_out_item pending_results[$];

    int idle_max        = 3;
    int beats_in        = 0;
    int beats_out       = 0;
    int group_starts    = 0;
    int avg_saturations = 0;
    int cfg_writes      = 0;
    int mismatches      = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // Operand as seen at the configured width.
    function automatic logic [DATA_W-1:0] as_operand(input logic [DATA_W-1:0] u);
        return wide_cfg ? u : {{32{u[31]}}, u[31:0]};
    endfunction

    // Signed Q48.16 mean of the running total, truncated and saturated.
    function automatic logic [DATA_W-1:0] mean_q48(input logic [DATA_W-1:0] total,
                                                   input logic [COUNT_BITS-1:0] count);
        logic              neg;
        logic [DATA_W-1:0] mag;
        logic [QUO_W-1:0]  num;
        logic [QUO_W-1:0]  quo;
        neg = total[DATA_W-1];
        mag = neg ? -total : total;
        num = QUO_W'(mag) << FRAC_BITS;
        quo = num / QUO_W'(count);
        if (neg) begin
            if (quo > QUO_W'(SAT_MIN)) begin
                avg_saturations++;
                return SAT_MIN;
            end
            return -quo[DATA_W-1:0];
        end
        if (quo > QUO_W'(SAT_MAX)) begin
            avg_saturations++;
            return SAT_MAX;
        end
        return quo[DATA_W-1:0];
    endfunction

    // Apply one input beat to the shadow group state and return its result.
    function automatic t_out_item aggregate_step(input t_in_item beat);
        t_out_item         res;
        logic [DATA_W-1:0] v;
        logic [DATA_W-1:0] x;
        if (beat.func == FUNC_GROUP) begin
            grp_count   = '0;
            grp_extreme = '0;
            grp_total   = '0;
            group_starts++;
        end else begin
            v = as_operand(beat.value);
            x = as_operand(grp_extreme);
            if (grp_count == '0)
                grp_extreme = v;
            else if (mode_cfg == MODE_MIN && $signed(v) < $signed(x))
                grp_extreme = v;
            else if (mode_cfg == MODE_MAX && $signed(x) < $signed(v))
                grp_extreme = v;
            else
                grp_extreme = x;
            grp_total = as_operand(as_operand(grp_total) + v);
            if (grp_count != '1)
                grp_count++;
        end

        case (mode_cfg)
            MODE_MIN, MODE_MAX: begin
                res.result = (grp_count != '0) ? as_operand(grp_extreme)
                                               : as_operand(default_cfg);
            end
            MODE_SUM: begin
                res.result = (grp_count != '0) ? as_operand(grp_total)
                                               : as_operand(default_cfg);
            end
            MODE_AVG: begin
                res.result = (grp_count != '0) ? mean_q48(as_operand(grp_total), grp_count)
                                               : default_cfg;
            end
            default: begin
                res.result = DATA_W'(grp_count);
            end
        endcase
        res.is_empty = (grp_count == '0);
        return res;
    endfunction

    // Mostly fully random values, plus extremes, narrow-boundary and small ones.
    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] v;
        int                s;
        case ($urandom_range(0, 7))
            0: v = SAT_MIN;
            1: v = SAT_MAX;
            2: begin
                s = $urandom_range(0, 200);
                s = s - 100;
                v = DATA_W'(s);
            end
            3: v = {$urandom(), ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff)};
            default: v = {$urandom(), $urandom()};
        endcase
        return v;
    endfunction

    // One register write: setup phase, then access phase until pready.
    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        case (idx)
            REG_MODE:    mode_cfg    = data[2:0];
            REG_WIDE:    wide_cfg    = data[0];
            REG_DEFAULT: default_cfg = data;
            default: ;
        endcase
        cfg_writes++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Stop sending and wait until every expected result has come back.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic configure(input logic [2:0] mode, input logic wide,
                             input logic [DATA_W-1:0] dflt);
        settle();
        write_reg(REG_MODE, DATA_W'(mode));
        write_reg(REG_WIDE, DATA_W'(wide));
        write_reg(REG_DEFAULT, dflt);
    endtask

    // Send one input beat after a random gap; valid stays up until accepted.
    task automatic send_beat(input logic func, input logic [DATA_W-1:0] value);
        t_in_item beat;
        int       gap;
        beat.func  = func;
        beat.value = value;
        gap = $urandom_range(0, idle_max);
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        pending_results.push_back(aggregate_step(beat));
        beats_in++;
    endtask

    // Result side: random stalls, then compare each beat with the oldest expectation.
    initial begin : result_checker
        t_out_item want;
        int        stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = $urandom_range(0, idle_max);
            repeat (stall) begin
                @(negedge i_clk);
                i_out_ready <= 1'b0;
            end
            @(negedge i_clk);
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            beats_out++;
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: result=%h is_empty=%b",
                       o_out_data.result, o_out_data.is_empty);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.result !== want.result) begin
                    $error("result: expected %h, got %h", want.result, o_out_data.result);
                    mismatches++;
                end
                if (o_out_data.is_empty !== want.is_empty) begin
                    $error("is_empty: expected %b, got %b", want.is_empty,
                           o_out_data.is_empty);
                    mismatches++;
                end
            end
        end
    end

    // Registers at their reset values, then an unused mode code acting as count.
    task automatic test_reset_and_count();
        send_beat(FUNC_FOLD, SAT_MIN);
        send_beat(FUNC_GROUP, SAT_MAX);
        configure(MODE_UNUSED_HI, 1'b1, SAT_MAX);
        send_beat(FUNC_FOLD, 64'd5);
    endtask

    // Min and max at the signed limits, wide and narrow, with an empty group first.
    task automatic test_min_max();
        configure(MODE_MIN, 1'b1, SAT_MIN);
        send_beat(FUNC_GROUP, '0);
        send_beat(FUNC_FOLD, SAT_MAX);
        send_beat(FUNC_FOLD, SAT_MIN);
        // Switching to max keeps the stored extreme of the open group.
        configure(MODE_MAX, 1'b1, SAT_MAX);
        send_beat(FUNC_FOLD, '0);
        send_beat(FUNC_FOLD, SAT_MAX);
        // Narrow mode: the upper half of values and of the default is ignored.
        configure(MODE_MIN, 1'b0, 64'h0123_4567_8000_0001);
        send_beat(FUNC_GROUP, '0);
        send_beat(FUNC_FOLD, 64'hffff_ffff_7fff_ffff);
        send_beat(FUNC_FOLD, 64'h0000_0000_8000_0000);
    endtask

    // The sum wraps at 32 bits in narrow mode and at 64 bits in wide mode.
    task automatic test_sum_wrap();
        configure(MODE_SUM, 1'b0, 64'h7654_3210_7fff_ffff);
        send_beat(FUNC_GROUP, '0);
        send_beat(FUNC_FOLD, 64'h0000_0000_7fff_ffff);
        send_beat(FUNC_FOLD, 64'd1);
        configure(MODE_SUM, 1'b1, SAT_MIN);
        send_beat(FUNC_GROUP, '0);
        send_beat(FUNC_FOLD, SAT_MAX);
        send_beat(FUNC_FOLD, 64'd1);
    endtask

    // Average: saturation both ways, truncation toward zero, full-width default.
    task automatic test_average();
        configure(MODE_AVG, 1'b1, SAT_MAX);
        send_beat(FUNC_GROUP, '0);
        send_beat(FUNC_FOLD, SAT_MAX);
        send_beat(FUNC_GROUP, '0);
        send_beat(FUNC_FOLD, SAT_MIN);
        send_beat(FUNC_GROUP, '0);
        send_beat(FUNC_FOLD, {DATA_W{1'b1}});
        send_beat(FUNC_FOLD, '0);
        send_beat(FUNC_FOLD, '0);
        configure(MODE_AVG, 1'b0, 64'hdead_beef_0000_0001);
        send_beat(FUNC_GROUP, '0);
        send_beat(FUNC_FOLD, 64'h5555_5555_ffff_fffd);
    endtask

    // Random segments, each under a fresh configuration; groups often span a change.
    task automatic test_random_groups();
        int         left;
        int         seg;
        int         m;
        logic       func;
        left = RANDOM_BEATS;
        while (left > 0) begin
            seg = $urandom_range(20, 60);
            if (seg > left)
                seg = left;
            m = $urandom_range(0, 11);
            configure((m > 7) ? MODE_AVG : 3'(m), 1'($urandom_range(0, 1)), pick_value());
            idle_max = ($urandom_range(0, 3) == 0) ? 0 : 3;
            for (int n = 0; n < seg; n++) begin
                func = ($urandom_range(0, 9) == 0) ? FUNC_GROUP : FUNC_FOLD;
                send_beat(func, pick_value());
            end
            left -= seg;
        end
        idle_max = 3;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_and_count();
        test_min_max();
        test_sum_wrap();
        test_average();
        test_random_groups();

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run: %0d input beats, %0d result beats, %0d group starts, %0d register writes",
                 beats_in, beats_out, group_starts, cfg_writes);
        $display("run: %0d saturated averages predicted, %0d mismatches",
                 avg_saturations, mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
